/* design/gtfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfr_pkg
// Shared codes for the glyph text frame renderer.
// ----------------------------------------------------------------------------
package gtfr_pkg;

  typedef enum logic [1:0] {
    OP_DRAW    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_FONT_WR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_FRAME   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_GLYPH = 2'd1,
    ST_CLIPPED  = 2'd2
  } status_e;

  localparam logic [7:0] FirstSymbol = 8'h20;
  localparam logic [7:0] CmdColLow   = 8'h00;
  localparam logic [7:0] CmdColHigh  = 8'h10;
  localparam logic [7:0] CmdPage     = 8'hB0;

endpackage

/* design/gtfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfr_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module gtfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end

endmodule

/* design/glyph_text_frame_renderer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_frame_renderer
// Page-organized text frame store with font memory, draw, clear and page refresh.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis (tuser carries the operation; tdata the line,
// symbol, page, font address and byte); results leave on m_axis, tuser
// carrying the result kind and status, tlast marking the final word of an input.
// One input is worked on at a time; s_axis_tready is high only when idle
// with no result word waiting. Work done for each input, in order:
//   font write, bad symbol : one status word
//   draw          : width fetch, then one font read and one frame write
//                   per cycle, then cursor update and a status word
//   clear         : one frame byte written per cycle, then a status word
//   refresh       : command word, then for each frame word four reads,
//                   one spare read and an output step; the last frame
//                   word carries tlast.
// The next input is taken in the cycle after the last result word leaves.
// A stalled receiver holds the current word; the block gathers at most one
// more frame word, then waits, and the input stays stalled.
// After reset the block sweeps the frame store to zero before the first input
// is taken. Cursors reset to zero; the font store is undefined until written.
// ----------------------------------------------------------------------------
module glyph_text_frame_renderer
  import gtfr_pkg::*;
#(
  parameter int FRAME_COLUMNS      = 128,
  parameter int GLYPH_COLUMNS      = 12,
  parameter int GLYPH_RECORD_BYTES = 25,
  parameter int FONT_GLYPHS        = 96
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] line_select, [8:1] symbol, [10:9] page_number,
  // [22:11] font_address, [30:23] font_byte, [31] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] payload_word, [39:32] cursor_after
  output logic [39:0] m_axis_tdata,
  // [1:0] result_kind, [3:2] status_code
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int FrameBytes = 4 * FRAME_COLUMNS;
  localparam int FaW        = $clog2(FrameBytes);
  localparam int FontBytes  = FONT_GLYPHS * GLYPH_RECORD_BYTES;
  localparam int FnW        = $clog2(FontBytes);
  localparam int ColW       = $clog2(FRAME_COLUMNS + 1);
  localparam int GcW        = $clog2(GLYPH_COLUMNS + 1);
  localparam int Words      = (FRAME_COLUMNS + 3) / 4;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FONT, S_DRAW_W, S_DRAW_C, S_DRAW_END,
    S_CLEAR, S_REF_CMD, S_REF_RD, S_REF_OUT, S_OUT
  } state_e;

  state_e state_q;

  // input fields
  logic [1:0]  in_op;
  logic        in_line;
  logic [7:0]  in_sym;
  logic [1:0]  in_page;
  logic [11:0] in_faddr;
  logic [7:0]  in_fbyte;
  logic        in_acc;
  logic        sym_bad;
  assign in_op    = s_axis_tuser;
  assign in_line  = s_axis_tdata[0];
  assign in_sym   = s_axis_tdata[8:1];
  assign in_page  = s_axis_tdata[10:9];
  assign in_faddr = s_axis_tdata[22:11];
  assign in_fbyte = s_axis_tdata[30:23];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign sym_bad  = in_sym < FirstSymbol ||
                    32'(in_sym - FirstSymbol) >= 32'(FONT_GLYPHS);

  logic            line_q;
  logic [1:0]      page_q;
  logic [FnW-1:0]  base_q;
  logic [ColW-1:0] upper_q, lower_q, cur_q;
  logic [FaW:0]    addr_cnt_q;
  logic [GcW:0]    step_q;       // draw: 2 per glyph column
  logic [1:0]      byte_q;
  logic [$clog2(Words+1)-1:0] word_q;
  logic            rd_pend_q;
  logic [7:0]      width_q;
  logic [31:0]     word_acc_q;

  // pending frame write address for draw (registered; written in the cycle after its font read)
  logic           fcol_p_ok_q;
  logic [FaW-1:0] fr_wa_q;

  // output register
  logic [31:0] o_payload_q;
  logic [7:0]  o_cursor_q;
  logic [1:0]  o_kind_q, o_status_q;
  logic        o_last_q, o_valid_q;

  // memory ports
  logic           fr_we, fn_we;
  logic [FaW-1:0] fr_addr;
  logic [7:0]     fr_wdata, fr_rdata, fn_rdata, fn_wdata;
  logic [FnW-1:0] fn_addr;

  gtfr_ram #(.Width(8), .Depth(FrameBytes)) u_frame (
    .clk_i, .we_i(fr_we), .addr_i(fr_addr), .wdata_i(fr_wdata), .rdata_o(fr_rdata));
  gtfr_ram #(.Width(8), .Depth(1 << FnW)) u_font (
    .clk_i, .we_i(fn_we), .addr_i(fn_addr), .wdata_i(fn_wdata), .rdata_o(fn_rdata));

  // draw column index and frame column of the current step
  logic [GcW-1:0]  gcol;
  logic [ColW:0]   fcol;
  logic [1:0]      dpage;
  assign gcol  = step_q[GcW:1];
  assign fcol  = {1'b0, cur_q} + (ColW+1)'(gcol);
  assign dpage = {line_q, step_q[0]};

  logic [ColW+8:0] sum_w;
  assign sum_w = (ColW+9)'(cur_q) + (ColW+9)'(width_q);

  // memory port control
  always_comb begin
    fr_we    = 1'b0;
    fr_addr  = '0;
    fr_wdata = fn_rdata;
    fn_we    = 1'b0;
    fn_addr  = '0;
    fn_wdata = in_fbyte;
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        fr_we    = 1'b1;
        fr_addr  = addr_cnt_q[FaW-1:0];
        fr_wdata = '0;
      end
      S_IDLE: begin
        fn_we   = in_acc && in_op == OP_FONT_WR &&
                  {20'd0, in_faddr} < 32'(FontBytes);
        fn_addr = in_faddr[FnW-1:0];
      end
      S_DRAW_W: fn_addr = base_q;
      S_DRAW_C: begin
        // write the byte fetched last cycle while the next one is read
        fn_addr = base_q + FnW'(step_q) + FnW'(1);
        fr_we   = rd_pend_q && fcol_p_ok_q;
        fr_addr = fr_wa_q;
      end
      S_REF_RD: fr_addr = FaW'(32'(page_q) * FRAME_COLUMNS + 32'(addr_cnt_q));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      addr_cnt_q  <= '0;
      upper_q     <= '0;
      lower_q     <= '0;
      o_valid_q   <= 1'b0;
      rd_pend_q   <= 1'b0;
      line_q      <= 1'b0;
      page_q      <= '0;
      base_q      <= '0;
      cur_q       <= '0;
      step_q      <= '0;
      byte_q      <= '0;
      word_q      <= '0;
      width_q     <= '0;
      word_acc_q  <= '0;
      fcol_p_ok_q <= 1'b0;
      fr_wa_q     <= '0;
      o_payload_q <= '0;
      o_cursor_q  <= '0;
      o_kind_q    <= KIND_STATUS;
      o_status_q  <= ST_OK;
      o_last_q    <= 1'b0;
    end else begin
      if (o_valid_q && m_axis_tready) o_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT, S_CLEAR: begin
          if (addr_cnt_q == (FaW+1)'(FrameBytes - 1)) begin
            addr_cnt_q <= '0;
            if (state_q == S_INIT) state_q <= S_IDLE;
            else state_q <= S_OUT;
          end else begin
            addr_cnt_q <= addr_cnt_q + 1'b1;
          end
        end
        S_IDLE: if (in_acc) begin
          line_q      <= in_line;
          page_q      <= in_page;
          cur_q       <= in_line ? lower_q : upper_q;
          addr_cnt_q  <= '0;
          o_kind_q    <= KIND_STATUS;
          o_payload_q <= '0;
          o_status_q  <= (op_e'(in_op) == OP_DRAW && sym_bad) ? ST_NO_GLYPH : ST_OK;
          o_last_q    <= 1'b1;
          o_cursor_q  <= 8'(in_line ? lower_q : upper_q);
          unique case (op_e'(in_op))
            OP_DRAW: begin
              if (sym_bad) begin
                state_q <= S_OUT;
              end else begin
                base_q  <= FnW'(32'(in_sym - FirstSymbol) * GLYPH_RECORD_BYTES);
                state_q <= S_DRAW_W;
              end
            end
            OP_CLEAR:   state_q <= S_CLEAR;
            OP_REFRESH: state_q <= S_REF_CMD;
            default:    state_q <= S_OUT;
          endcase
        end
        S_DRAW_W: begin
          step_q    <= '0;
          rd_pend_q <= 1'b0;
          state_q   <= S_DRAW_C;
        end
        S_DRAW_C: begin
          if (!rd_pend_q) width_q <= fn_rdata;
          rd_pend_q   <= 1'b1;
          fcol_p_ok_q <= fcol < (ColW+1)'(FRAME_COLUMNS);
          fr_wa_q     <= FaW'(32'(dpage) * FRAME_COLUMNS + 32'(fcol));
          step_q      <= step_q + 1'b1;
          if (step_q == (GcW+1)'(2 * GLYPH_COLUMNS)) state_q <= S_DRAW_END;
        end
        S_DRAW_END: begin
          rd_pend_q <= 1'b0;
          if (sum_w > (ColW+9)'(FRAME_COLUMNS)) begin
            o_status_q <= ST_CLIPPED;
            o_cursor_q <= 8'(FRAME_COLUMNS);
            if (line_q) lower_q <= ColW'(FRAME_COLUMNS); else upper_q <= ColW'(FRAME_COLUMNS);
          end else begin
            o_cursor_q <= 8'(sum_w);
            if (line_q) lower_q <= ColW'(sum_w); else upper_q <= ColW'(sum_w);
          end
          state_q <= S_OUT;
        end
        S_REF_CMD: if (!o_valid_q) begin
          o_kind_q    <= KIND_COMMAND;
          o_payload_q <= {8'd0, CmdPage | {6'd0, page_q}, CmdColHigh, CmdColLow};
          o_cursor_q  <= '0;
          o_last_q    <= 1'b0;
          o_valid_q   <= 1'b1;
          addr_cnt_q  <= '0;
          byte_q      <= '0;
          word_q      <= '0;
          word_acc_q  <= '0;
          rd_pend_q   <= 1'b0;
          state_q     <= S_REF_RD;
        end
        S_REF_RD: begin
          // read issued this cycle; capture previous read
          if (rd_pend_q) begin
            word_acc_q[8*byte_q +: 8] <= fr_rdata;
            byte_q <= byte_q + 1'b1;
          end
          // on a full word the read issued now is dropped and re-issued later
          if (addr_cnt_q == (FaW+1)'(FRAME_COLUMNS) ||
              (rd_pend_q && byte_q == 2'd3)) begin
            state_q   <= S_REF_OUT;
            rd_pend_q <= 1'b0;
          end else begin
            rd_pend_q  <= 1'b1;
            addr_cnt_q <= addr_cnt_q + 1'b1;
          end
        end
        S_REF_OUT: if (!o_valid_q) begin
          o_kind_q    <= KIND_FRAME;
          o_payload_q <= word_acc_q;
          o_last_q    <= word_q == ($clog2(Words+1))'(Words - 1);
          o_valid_q   <= 1'b1;
          word_acc_q  <= '0;
          byte_q      <= '0;
          word_q      <= word_q + 1'b1;
          state_q     <= word_q == ($clog2(Words+1))'(Words - 1) ? S_IDLE : S_REF_RD;
        end
        S_OUT: if (!o_valid_q) begin
          o_valid_q <= 1'b1;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE && !o_valid_q;
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_cursor_q, o_payload_q};
  assign m_axis_tuser  = {o_status_q, o_kind_q};
  assign m_axis_tlast  = o_last_q;

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !o_valid_q) else $error("accept while output busy");
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upper_q <= ColW'(FRAME_COLUMNS) && lower_q <= ColW'(FRAME_COLUMNS))
    else $error("cursor beyond frame");
  a_status_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_kind_q != KIND_STATUS |-> o_status_q == ST_OK)
    else $error("status on data word");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph text frame renderer: loads a few glyphs,
// draws, clears and refreshes pages, and compares every output word against
// a behavioral model of the frame store, font store and cursors.
// ----------------------------------------------------------------------------
module tb_top;
  import gtfr_pkg::*;

  localparam int Cols       = 128;
  localparam int GlyphCols  = 12;
  localparam int RecBytes   = 25;
  localparam int Glyphs     = 96;
  localparam int FontBytes  = Glyphs * RecBytes;
  localparam int CycleLimit = 400000;
  localparam int Sym0       = int'(FirstSymbol);

  typedef struct packed {
    op_e         op;
    logic        line;
    logic [7:0]  symbol;
    logic [1:0]  page;
    logic [11:0] faddr;
    logic [7:0]  fbyte;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] payload;
    logic        last;
    status_e     status;
    logic [7:0]  cursor;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  glyph_text_frame_renderer uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // Model state
  logic [7:0] frame_mem [4*Cols];
  logic [7:0] font_mem  [FontBytes];
  bit         font_set  [FontBytes];
  int unsigned cur_upper, cur_lower;
  word_t      pending_words [$];
  int         loaded_glyphs [$];

  int  error_count = 0;
  int  tx_idle = 0, rx_idle = 0;
  int  hold_cycles = 0;
  int  cycle_count = 0;

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random backpressure, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Compare each output word with the oldest expected one
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", m_axis_tdata, '0);
      end else begin
        w = pending_words.pop_front();
        if (m_axis_tuser[1:0] != w.kind)
          report("kind", 40'(m_axis_tuser[1:0]), 40'(w.kind));
        if (m_axis_tdata[31:0] != w.payload)
          report("payload", 40'(m_axis_tdata[31:0]), 40'(w.payload));
        if (m_axis_tlast != w.last)
          report("last", 40'(m_axis_tlast), 40'(w.last));
        if (m_axis_tuser[3:2] != w.status)
          report("status", 40'(m_axis_tuser[3:2]), 40'(w.status));
        if (m_axis_tdata[39:32] != w.cursor)
          report("cursor", 40'(m_axis_tdata[39:32]), 40'(w.cursor));
      end
    end
  end

  function automatic logic [7:0] font_rd(int unsigned a);
    return (a < FontBytes) ? font_mem[a] : 8'h00;
  endfunction

  function automatic bit glyph_ready(int idx);
    for (int k = 0; k < RecBytes; k++)
      if (!font_set[idx*RecBytes+k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic word_t status_word(status_e st, int unsigned cur);
    word_t w;
    w.kind = KIND_STATUS; w.payload = '0; w.last = 1'b1; w.status = st; w.cursor = cur[7:0];
    return w;
  endfunction

  // Work out the words an accepted request produces and update the model
  task automatic predict(input req_t r);
    int unsigned cur, base, col, pg0, sum;
    status_e st;
    word_t w;
    cur = r.line ? cur_lower : cur_upper;
    case (r.op)
      OP_DRAW: begin
        st = ST_OK;
        if (int'(r.symbol) < Sym0 || int'(r.symbol) - Sym0 >= Glyphs) begin
          st = ST_NO_GLYPH;
        end else begin
          base = (int'(r.symbol) - Sym0) * RecBytes;
          pg0  = r.line ? 2 : 0;
          for (int i = 0; i < GlyphCols; i++) begin
            col = cur + i;
            if (col < Cols) begin
              frame_mem[pg0*Cols+col]     = font_rd(base + 1 + 2*i);
              frame_mem[(pg0+1)*Cols+col] = font_rd(base + 2 + 2*i);
            end
          end
          sum = cur + font_rd(base);
          if (sum > Cols) begin
            sum = Cols;
            st  = ST_CLIPPED;
          end
          cur = sum;
          if (r.line) cur_lower = cur; else cur_upper = cur;
        end
        pending_words.push_back(status_word(st, cur));
      end
      OP_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        pending_words.push_back(status_word(ST_OK, cur));
      end
      OP_REFRESH: begin
        w.kind = KIND_COMMAND; w.last = 1'b0; w.status = ST_OK; w.cursor = '0;
        w.payload = {8'h00, CmdPage | {6'b0, r.page}, CmdColHigh, CmdColLow};
        pending_words.push_back(w);
        for (int k = 0; k < (Cols + 3) / 4; k++) begin
          w.kind = KIND_FRAME;
          w.last = (k + 1 == (Cols + 3) / 4);
          w.payload = '0;
          for (int b = 0; b < 4; b++)
            if (k*4 + b < Cols) w.payload[8*b +: 8] = frame_mem[r.page*Cols + k*4 + b];
          pending_words.push_back(w);
        end
      end
      default: begin
        if (r.faddr < FontBytes) begin
          font_mem[r.faddr] = r.fbyte;
          font_set[r.faddr] = 1'b1;
        end
        pending_words.push_back(status_word(ST_OK, cur));
      end
    endcase
  endtask

  // Offer one request; valid stays high into the next call
  task automatic send(input req_t r);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {1'b0, r.fbyte, r.faddr, r.page, r.symbol, r.line};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(r);
    @(negedge clk_i);
  endtask

  function automatic req_t noise_req(op_e op);
    req_t r;
    r.op = op; r.line = 1'($urandom_range(1)); r.symbol = 8'($urandom_range(255));
    r.page = 2'($urandom_range(3)); r.faddr = 12'($urandom_range(4095));
    r.fbyte = 8'($urandom_range(255));
    return r;
  endfunction

  task automatic font_wr(input int unsigned a, input int unsigned v);
    req_t r;
    r = noise_req(OP_FONT_WR); r.faddr = a[11:0]; r.fbyte = v[7:0];
    send(r);
  endtask

  task automatic draw(input bit line, input int unsigned sym);
    req_t r;
    r = noise_req(OP_DRAW); r.line = line; r.symbol = sym[7:0];
    send(r);
  endtask

  task automatic refresh(input int unsigned pg);
    req_t r;
    r = noise_req(OP_REFRESH); r.page = pg[1:0];
    send(r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Load whole glyph records; widths small so the cursors move slowly
  task automatic test_font_load();
    int idx;
    int picks [$];
    picks = '{0, Glyphs - 1};
    repeat (1) picks.push_back($urandom_range(1, Glyphs - 2));
    foreach (picks[p]) begin
      idx = picks[p];
      if (!glyph_ready(idx)) begin
        font_wr(idx*RecBytes, (p == 0) ? 0 : $urandom_range(1, 5));
        for (int k = 1; k < RecBytes; k++) font_wr(idx*RecBytes + k, $urandom_range(255));
        loaded_glyphs.push_back(idx);
      end
    end
    drain();
  endtask

  task automatic test_directed();
    draw(0, Sym0);                     // first glyph, zero width
    draw(1, Sym0 + Glyphs - 1);        // last glyph
    draw(0, Sym0 + Glyphs - 1);
    draw(0, Sym0 - 1);                 // just below the font
    draw(1, Sym0 + Glyphs);            // just past the font
    draw(0, 0);
    draw(1, 255);
    for (int p = 0; p < 4; p++) refresh(p);
    font_wr(FontBytes, 8'hFF);         // writes past the font are dropped
    font_wr(4095, 8'hAA);
    font_wr((Glyphs - 1)*RecBytes + 24, 8'hFF);
    font_wr((Glyphs - 1)*RecBytes + 1, 8'h00);
    draw(1, Sym0 + Glyphs - 1);
    refresh(2);
    refresh(3);
    begin
      req_t r;
      r = noise_req(OP_CLEAR);
      send(r);
    end
    refresh(0);
    refresh(3);
    drain();
  endtask

  task automatic test_random(input int n);
    req_t r;
    int sel, g;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        r = noise_req(OP_DRAW);
        if ($urandom_range(4) != 0)
          r.symbol = 8'(Sym0 + loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)]);
        else if ($urandom_range(1))
          r.symbol = 8'($urandom_range(Sym0 - 1));
        else
          r.symbol = 8'($urandom_range(255, Sym0 + Glyphs));
      end else if (sel < 40) begin
        r = noise_req(OP_CLEAR);
      end else if (sel < 62) begin
        r = noise_req(OP_REFRESH);
      end else begin
        r = noise_req(OP_FONT_WR);
        // keep widths under control: rewrite column bytes of loaded glyphs
        if ($urandom_range(3) != 0) begin
          g = loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)];
          r.faddr = 12'(g*RecBytes + $urandom_range(1, RecBytes - 1));
        end else begin
          r.faddr = 12'($urandom_range(4095, FontBytes));
        end
      end
      send(r);
    end
    drain();
  endtask

  // Long receiver hold-off while refreshes keep coming
  task automatic test_backpressure();
    hold_cycles = 600;
    for (int p = 0; p < 4; p++) refresh(p);
    draw(0, Sym0 + loaded_glyphs[1]);
    drain();
  endtask

  // Fill both lines to the edge: columns past the frame drop, cursor saturates
  task automatic test_line_full();
    int g;
    g = Glyphs - 1;
    font_wr(g*RecBytes, 11);
    for (int ln = 0; ln < 2; ln++) begin
      while ((ln ? cur_lower : cur_upper) < Cols) draw(ln[0], Sym0 + g);
      draw(ln[0], Sym0 + g);
    end
    font_wr(g*RecBytes, 255);
    draw(0, Sym0 + g);
    draw(1, Sym0);
    for (int p = 0; p < 4; p++) refresh(p);
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
    foreach (font_mem[i]) begin
      font_mem[i] = 8'h00;
      font_set[i] = 1'b0;
    end
    cur_upper = 0;
    cur_lower = 0;

    tx_idle = 8;  rx_idle = 62;
    test_font_load();
    test_directed();
    test_random(15);
    tx_idle = 62; rx_idle = 8;
    test_random(15);
    test_backpressure();
    tx_idle = 0;  rx_idle = 0;
    test_random(15);
    test_line_full();

    repeat (100) @(posedge clk_i);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
